@@ sv/material_name_classifier_macros.svh @@
// Assertion macros for the material name classifier.
// Each macro expects signals clk and arst_n in the including scope.
`ifndef MATERIAL_NAME_CLASSIFIER_MACROS_SVH
`define MATERIAL_NAME_CLASSIFIER_MACROS_SVH

// Same-cycle implication, disabled while in reset
`define MCLS_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while in reset
`define MCLS_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ sv/mcls_pkg.sv @@
// Shared types, needle constants and byte helpers for the material name classifier.
// No dependencies; used by mcls_cell, mcls_match and material_name_classifier.
`timescale 1ns / 1ps

package mcls_pkg;

	// Window depth in characters, current one included
	localparam int WINDOW_CHARS = 10;
	localparam int BASE_NEEDLES = 20;
	localparam int FOUND_W      = 26;

	// Found flag positions above the base needles
	localparam int BIT_CARBON     = 20;
	localparam int BIT_GLASS      = 21;
	localparam int BIT_FIBERGLASS = 22;
	localparam int BIT_CF         = 23;
	localparam int BIT_GF         = 24;
	localparam int BIT_GF25       = 25;

	typedef enum logic [3:0] {
		BASE_PAHT = 4'd0,
		BASE_PPA  = 4'd1,
		BASE_PPS  = 4'd2,
		BASE_PCTG = 4'd3,
		BASE_PETG = 4'd4,
		BASE_PET  = 4'd5,
		BASE_TPU  = 4'd6,
		BASE_PVA  = 4'd7,
		BASE_ASA  = 4'd8,
		BASE_ABS  = 4'd9,
		BASE_HIPS = 4'd10,
		BASE_PC   = 4'd11,
		BASE_PP   = 4'd12,
		BASE_PA   = 4'd13,
		BASE_PLA  = 4'd14
	} base_code_t;

	typedef enum logic [1:0] {
		FIBRE_NONE = 2'd0,
		FIBRE_CF   = 2'd1,
		FIBRE_GF   = 2'd2
	} fibre_code_t;

	// Needle text: byte j holds the character j positions back from the end,
	// so a string literal lands with its last letter in the low byte.
	// Bytes past the needle length are zero.
	typedef logic [8*WINDOW_CHARS-1:0] needle_t;

	// Lowercased window: byte k is the character k positions back (0 = current)
	typedef logic [WINDOW_CHARS-1:0][7:0] win_t;

	localparam needle_t BASE_NEEDLE [BASE_NEEDLES] = '{
		needle_t'("paht"), needle_t'("ppa"),  needle_t'("pps"),   needle_t'("pctg"),
		needle_t'("petg"), needle_t'("pet-"), needle_t'("pet "),  needle_t'("tpu"),
		needle_t'("tpe"),  needle_t'("pva"),  needle_t'("bvoh"),  needle_t'("asa"),
		needle_t'("abs"),  needle_t'("hips"), needle_t'("pc"),    needle_t'("pp"),
		needle_t'("pa12"), needle_t'("nylon"), needle_t'("pa"),   needle_t'("pla")
	};

	localparam base_code_t BASE_CODE [BASE_NEEDLES] = '{
		BASE_PAHT, BASE_PPA, BASE_PPS, BASE_PCTG, BASE_PETG, BASE_PET, BASE_PET,
		BASE_TPU, BASE_TPU, BASE_PVA, BASE_PVA, BASE_ASA, BASE_ABS, BASE_HIPS,
		BASE_PC, BASE_PP, BASE_PA, BASE_PA, BASE_PA, BASE_PLA
	};

	// Fibre substrings: carbon, glass, fiberglass
	localparam needle_t SUB_NEEDLE [3] = '{
		needle_t'("carbon"), needle_t'("glass"), needle_t'("fiberglass")
	};

	// Bounded tokens: CF, GF, GF25, with the window position of the left neighbor
	localparam needle_t TOK_NEEDLE [3] = '{
		needle_t'("cf"), needle_t'("gf"), needle_t'("gf25")
	};
	localparam int TOK_LEFT [3] = '{2, 2, 4};

	// Cell control, shared by every stage of the window
	typedef struct packed {
		logic shift;
		logic clear;
	} cell_ctrl_t;

	// What each window cell presents to the matcher and to its neighbor
	typedef struct packed {
		logic [7:0] raw;
		logic [7:0] lower;
		logic       alnum;
	} cell_tap_t;

	// Matches ending at the current character
	typedef struct packed {
		logic [2:0]              tok;
		logic [2:0]              sub;
		logic [BASE_NEEDLES-1:0] base;
		logic                    cur_alnum;
	} hits_t;

	function automatic logic [7:0] to_lower(input logic [7:0] c);
		if (c >= 8'h41 && c <= 8'h5A) begin
			return c + 8'd32;
		end
		return c;
	endfunction

	function automatic logic is_alnum(input logic [7:0] c);
		return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
			(c >= 8'h61 && c <= 8'h7A);
	endfunction

	// Needle letters are never zero, so empty window slots never match
	function automatic logic ends_here(input win_t w, input needle_t n);
		logic ok;
		ok = 1'b1;
		for (int j = 0; j < WINDOW_CHARS; j++) begin
			if (n[8*j +: 8] != 8'd0 && w[j] != n[8*j +: 8]) begin
				ok = 1'b0;
			end
		end
		return ok;
	endfunction

endpackage

@@ sv/mcls_cell.sv @@
// One character cell of the classifier window: holds a byte, hands it on.
// Depends on mcls_pkg for the control and tap types and byte helpers.
`timescale 1ns / 1ps

module mcls_cell
	import mcls_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  cell_ctrl_t ctrl,
	input  logic [7:0] din,
	output cell_tap_t  tap
);

	logic [7:0] byte_q;

	// Clear at end of name, otherwise advance on each taken character
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_q <= 8'd0;
		end else if (ctrl.clear) begin
			byte_q <= 8'd0;
		end else if (ctrl.shift) begin
			byte_q <= din;
		end
	end

	// Present the stored byte, folded to lower case, and its class
	assign tap.raw   = byte_q;
	assign tap.lower = to_lower(byte_q);
	assign tap.alnum = is_alnum(byte_q);

endmodule

@@ sv/mcls_match.sv @@
// Parallel needle compare over the current character and the window cells.
// Depends on mcls_pkg for needle tables, window and hit types.
`timescale 1ns / 1ps

module mcls_match
	import mcls_pkg::*;
(
	input  logic [7:0] cur,
	input  cell_tap_t  taps [WINDOW_CHARS-1],
	output hits_t      hits
);

	win_t w;
	logic [WINDOW_CHARS-1:0] alnum_at;

	// Assemble the lowercased window, current character at position zero
	always_comb begin
		w[0]        = to_lower(cur);
		alnum_at[0] = is_alnum(cur);
		for (int k = 1; k < WINDOW_CHARS; k++) begin
			w[k]        = taps[k-1].lower;
			alnum_at[k] = taps[k-1].alnum;
		end
	end

	// Compare every needle against the window in parallel
	always_comb begin
		hits.cur_alnum = alnum_at[0];
		for (int i = 0; i < BASE_NEEDLES; i++) begin
			hits.base[i] = ends_here(w, BASE_NEEDLE[i]);
		end
		for (int i = 0; i < 3; i++) begin
			hits.sub[i] = ends_here(w, SUB_NEEDLE[i]);
			// a token needs a non-alphanumeric left neighbor or the name start
			hits.tok[i] = ends_here(w, TOK_NEEDLE[i]) && !alnum_at[TOK_LEFT[i]];
		end
	end

endmodule

@@ sv/material_name_classifier.sv @@
// Material name classifier: takes one character per cycle, back to back, with
// no gap between names. Each character shifts into a row of nine window cells
// and is compared against all needles in the same cycle; on the character
// marked tlast the base and fibre codes are registered and shown on the
// master side in the next cycle, and the state is cleared for the next name.
// The slave side stalls only while a finished result waits and m_tready is low.
// Depends on mcls_pkg, mcls_cell, mcls_match and the assertion macro header.
`timescale 1ns / 1ps
`include "material_name_classifier_macros.svh"

module material_name_classifier
	import mcls_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] char_code
	input  logic       s_tuser,   // [0] has_char
	input  logic       s_tlast,   // end_of_name
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata    // [3:0] base_code, [5:4] fibre_code, [7:6] zero
);

	logic                s_xfer;
	logic                take;
	cell_ctrl_t          ctrl;
	cell_tap_t           taps [WINDOW_CHARS-1];
	hits_t               hits;
	logic [FOUND_W-1:0]  found_q;
	logic [2:0]          pending_q;
	logic [2:0]          resolved;
	logic [FOUND_W-1:0]  found_take;
	logic [2:0]          pending_next;
	logic [FOUND_W-1:0]  found_final;
	base_code_t          base_sel;
	fibre_code_t         fibre_sel;
	logic                m_tvalid_q;
	base_code_t          base_q;
	fibre_code_t         fibre_q;

	// Accept while the result register is free or being drained
	assign s_tready = !m_tvalid_q || m_tready;
	assign s_xfer   = s_tvalid && s_tready;
	assign take     = s_xfer && s_tuser;

	assign ctrl.shift = take;
	assign ctrl.clear = s_xfer && s_tlast;

	// Chain of window cells, newest first
	for (genvar g = 0; g < WINDOW_CHARS-1; g++) begin : g_cell
		if (g == 0) begin : g_head
			mcls_cell u_cell (
				.clk   (clk),
				.arst_n(arst_n),
				.ctrl  (ctrl),
				.din   (s_tdata),
				.tap   (taps[g])
			);
		end else begin : g_body
			mcls_cell u_cell (
				.clk   (clk),
				.arst_n(arst_n),
				.ctrl  (ctrl),
				.din   (taps[g-1].raw),
				.tap   (taps[g])
			);
		end
	end

	mcls_match u_match (
		.cur (s_tdata),
		.taps(taps),
		.hits(hits)
	);

	// Merge this character's matches; resolve tokens on a right boundary
	always_comb begin
		resolved     = (take && !hits.cur_alnum) ? pending_q : 3'b000;
		found_take   = found_q | (take ? {resolved, hits.sub, hits.base} : '0);
		pending_next = take ? hits.tok : pending_q;
		// end of name is a right boundary too
		found_final  = found_take | {pending_next, {(FOUND_W-3){1'b0}}};
	end

	// Pick the first base needle in table order, PLA by default; fibre code CF over GF, else none
	always_comb begin
		base_sel = BASE_PLA;
		for (int i = BASE_NEEDLES-1; i >= 0; i--) begin
			if (found_final[i]) begin
				base_sel = BASE_CODE[i];
			end
		end
		if (found_final[BIT_CF] || found_final[BIT_CARBON]) begin
			fibre_sel = FIBRE_CF;
		end else if (found_final[BIT_GF] || found_final[BIT_GF25] ||
				found_final[BIT_GLASS] || found_final[BIT_FIBERGLASS]) begin
			fibre_sel = FIBRE_GF;
		end else begin
			fibre_sel = FIBRE_NONE;
		end
	end

	// Hold sticky flags and pending tokens; drop them at end of name
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q   <= '0;
			pending_q <= 3'b000;
		end else if (s_xfer) begin
			if (s_tlast) begin
				found_q   <= '0;
				pending_q <= 3'b000;
			end else begin
				found_q   <= found_take;
				pending_q <= pending_next;
			end
		end
	end

	// Result valid: set on the last transfer, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (s_xfer && s_tlast) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (s_xfer && s_tlast) begin
			base_q  <= base_sel;
			fibre_q <= fibre_sel;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {2'b00, fibre_q, base_q};

	// Checks
	`MCLS_ASSERT_NXT(a_result_follows_last, s_xfer && s_tlast, m_tvalid_q,
		"no result after a last transfer")
	`MCLS_ASSERT_NXT(a_state_cleared, s_xfer && s_tlast,
		found_q == '0 && pending_q == 3'b000, "state not cleared after end of name")
	`MCLS_ASSERT_IMP(a_codes_in_range, m_tvalid_q,
		m_tdata[5:4] != 2'd3 && m_tdata[3:0] != 4'd15, "result code out of range")

endmodule
